// File: rtl/pee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path escape encoder package
// Beat types, character constants and the byte classification helpers.
// ----------------------------------------------------------------------------
package pee_pkg;

	localparam int unsigned MAX_RESULTS = 6;
	localparam int unsigned CNT_W       = 3;
	localparam int unsigned CFG_IDX_W   = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_COLON   = 1'b1;

	// Hold codes of the encoder.
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_PCT   = 2'd1;
	localparam logic [1:0] MODE_DIGIT = 2'd2;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_X     = 8'h78;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// All output bytes caused by one input beat.
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [CNT_W-1:0]            count;
		logic                        last;
	} group_t;

	function automatic logic is_hex(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
			(b >= 8'h41 && b <= 8'h46);
	endfunction

	function automatic logic passes_raw(input logic [7:0] b, input logic colon);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7a) ||
			(b >= 8'h41 && b <= 8'h5a) || (b == CH_SLASH) ||
			(colon && (b == CH_COLON));
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
	endfunction

	function automatic group_t push(input group_t g, input logic [7:0] b);
		group_t r;
		r = g;
		r.bytes[r.count] = b;
		r.count = r.count + CNT_W'(1);
		return r;
	endfunction

	// A byte outside any percent sequence: raw or backslash-x with two digits.
	function automatic group_t encode(input group_t g, input logic [7:0] b,
			input logic colon);
		group_t r;
		r = g;
		if (passes_raw(b, colon)) begin
			r = push(r, b);
		end else begin
			r = push(r, CH_BSL);
			r = push(r, CH_X);
			r = push(r, hex_char(b[7:4]));
			r = push(r, hex_char(b[3:0]));
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/pee_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path escape encoder core
// Turns one registered input beat into its group of output bytes and keeps
// the held percent sign and digit between beats.
// ----------------------------------------------------------------------------
module pee_encoder
	import pee_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t item,
	input  wire logic     advance,
	input  wire logic     escape_enable,
	input  wire logic     allow_colon,
	output group_t        group
);

	logic [1:0] mode_q;
	logic [7:0] digit_q;
	logic [1:0] mode_nxt;
	logic [7:0] digit_nxt;
	group_t     g;

	always_comb begin
		g         = '0;
		mode_nxt  = mode_q;
		digit_nxt = digit_q;
		if (!escape_enable) begin
			if (mode_q == MODE_PCT || mode_q == MODE_DIGIT) g = push(g, CH_PCT);
			if (mode_q == MODE_DIGIT) g = push(g, digit_q);
			mode_nxt = MODE_NONE;
			g = push(g, item.in_byte);
		end else begin
			unique case (mode_q)
				MODE_PCT: begin
					if (is_hex(item.in_byte)) begin
						mode_nxt  = MODE_DIGIT;
						digit_nxt = item.in_byte;
					end else if (item.in_byte == CH_PCT) begin
						mode_nxt = MODE_NONE;
						g = push(g, CH_PCT);
					end else begin
						mode_nxt = MODE_NONE;
						g = push(g, CH_PCT);
						g = encode(g, item.in_byte, allow_colon);
					end
				end
				MODE_DIGIT: begin
					mode_nxt = MODE_NONE;
					if (is_hex(item.in_byte)) begin
						g = push(g, CH_BSL);
						g = push(g, CH_X);
						g = push(g, digit_q);
						g = push(g, item.in_byte);
					end else begin
						g = push(g, CH_PCT);
						g = push(g, digit_q);
						if (item.in_byte == CH_PCT) mode_nxt = MODE_PCT;
						else g = encode(g, item.in_byte, allow_colon);
					end
				end
				default: begin
					mode_nxt = MODE_NONE;
					if (item.in_byte == CH_PCT) mode_nxt = MODE_PCT;
					else g = encode(g, item.in_byte, allow_colon);
				end
			endcase
			// The end of a path flushes whatever is still held.
			if (item.in_last) begin
				if (mode_nxt == MODE_PCT || mode_nxt == MODE_DIGIT) g = push(g, CH_PCT);
				if (mode_nxt == MODE_DIGIT) g = push(g, digit_nxt);
				mode_nxt = MODE_NONE;
			end
		end
		g.last = item.in_last;
	end

	assign group = g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NONE;
			digit_q <= 8'd0;
		end else if (advance) begin
			mode_q  <= mode_nxt;
			digit_q <= digit_nxt;
		end
	end

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3)
		else $error("pee_encoder: illegal hold code");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.in_last |=> mode_q == MODE_NONE)
		else $error("pee_encoder: hold survived the end of a path");

endmodule
`default_nettype wire

// File: rtl/pee_serializer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path escape encoder serializer
// Holds one group of output bytes and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module pee_serializer
	import pee_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire group_t group,
	input  wire logic   load,
	output logic        load_ready,
	output logic        out_valid,
	input  wire logic   out_ready,
	output out_item_t   out_data
);

	group_t           grp_q;
	logic             valid_q;
	logic [CNT_W-1:0] idx_q;
	logic             final_beat;
	logic             fire;

	assign final_beat = (idx_q == grp_q.count - CNT_W'(1));
	assign fire       = valid_q && out_ready;
	assign load_ready = !valid_q || (fire && final_beat);

	assign out_valid         = valid_q;
	assign out_data.out_byte = grp_q.bytes[idx_q];
	assign out_data.out_last = grp_q.last && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load && load_ready) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (fire && final_beat) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ready) grp_q <= group;
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q < grp_q.count)
		else $error("pee_serializer: index beyond group");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> grp_q.count != '0 && grp_q.count <= CNT_W'(MAX_RESULTS))
		else $error("pee_serializer: bad group size");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !final_beat |=> valid_q && idx_q == $past(idx_q) + CNT_W'(1))
		else $error("pee_serializer: byte skipped or repeated");

endmodule
`default_nettype wire

// File: rtl/path_escape_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path escape encoder
// Streams path bytes and emits them hex-escaped, one output byte per beat.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  in      | in_valid / in_ready  | in_data  (in_byte, in_last)
//  out     | out_valid/ out_ready | out_data (out_byte, out_last)
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// An input beat is registered, encoded in the next cycle and its 0 to 6
// output bytes go out one per cycle from the group register while out_ready is high.
// The output port sets the pace: a byte outside a percent sequence
// produces at most four output bytes.
// A new input beat is taken while the previous group is still draining.
// Reset clears the hold and sets escaping on and colon escaping on.
// ----------------------------------------------------------------------------
module path_escape_encoder
	import pee_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	in_item_t item_q;
	logic     item_valid_q;
	logic     escape_enable_q;
	logic     allow_colon_q;
	group_t   group;
	logic     load_ready;
	logic     take;

	// A beat that produces nothing is consumed without loading the serializer.
	assign take     = item_valid_q && (group.count == '0 || load_ready);
	assign in_ready = !item_valid_q || take;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			item_valid_q <= 1'b1;
		end else if (take) begin
			item_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_enable_q <= 1'b1;
			allow_colon_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ESCAPE_ENABLE: escape_enable_q <= cfg_data[0];
				REG_ALLOW_COLON:   allow_colon_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pee_encoder u_encoder (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item_q),
		.advance       (take),
		.escape_enable (escape_enable_q),
		.allow_colon   (allow_colon_q),
		.group         (group)
	);

	pee_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.group      (group),
		.load       (take && group.count != '0),
		.load_ready (load_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path escape encoder testbench
// Drives byte paths through the encoder under random input gaps and output
// stalls. Every accepted beat is run through a predictor of the escaping
// rules, and each output beat is checked in order against the queue of
// expected bytes. Both configuration registers are exercised between phases.
// ----------------------------------------------------------------------------
module tb;
	import pee_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	// Predictor state: the hold and the register copies.
	logic [1:0] hold_mode;
	logic [7:0] hold_digit;
	logic       esc_on;
	logic       colon_ok;
	logic [7:0] step_bytes[$];
	out_item_t  escaped_q[$];

	int unsigned mismatch_count = 0;
	int unsigned beats_sent = 0;

	// Idling controls.
	bit          gaps_on = 1'b0;
	bit          stall_on = 1'b0;
	int unsigned burst_left = 0;
	logic [15:0] stall_pat = 16'hffff;
	logic [3:0]  stall_phase = 4'd0;

	path_escape_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// The receiver stalls on a rotating pattern that is redrawn when the phase wraps.
	// Bit 0 is always set, so no stall runs past the return of the phase to zero.
	always @(posedge clk) begin
		stall_phase <= stall_phase + 4'd1;
		if (stall_phase == 4'hf) begin
			stall_pat <= 16'($urandom) | 16'h0001;
		end
		out_ready <= !stall_on || stall_pat[stall_phase];
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic bit is_hex_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic bit keeps_raw(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
			(c >= "A" && c <= "Z") || c == CH_SLASH || (colon_ok && c == CH_COLON);
	endfunction

	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h61 + 8'(n) - 8'd10;
	endfunction

	function automatic void emit_plain(input logic [7:0] c);
		if (keeps_raw(c)) begin
			step_bytes.push_back(c);
		end else begin
			step_bytes.push_back(CH_BSL);
			step_bytes.push_back(CH_X);
			step_bytes.push_back(nibble_char(c[7:4]));
			step_bytes.push_back(nibble_char(c[3:0]));
		end
	endfunction

	function automatic void take_fresh(input logic [7:0] c);
		if (c == CH_PCT) begin
			hold_mode = MODE_PCT;
		end else begin
			emit_plain(c);
		end
	endfunction

	// Anything still held goes out raw.
	function automatic void release_hold();
		if (hold_mode != MODE_NONE) begin
			step_bytes.push_back(CH_PCT);
		end
		if (hold_mode == MODE_DIGIT) begin
			step_bytes.push_back(hold_digit);
		end
		hold_mode = MODE_NONE;
	endfunction

	function automatic void predict_escape(input logic [7:0] c, input logic last);
		out_item_t e;
		step_bytes.delete();
		if (!esc_on) begin
			release_hold();
			step_bytes.push_back(c);
		end else begin
			case (hold_mode)
				MODE_PCT: begin
					if (is_hex_char(c)) begin
						hold_mode = MODE_DIGIT;
						hold_digit = c;
					end else if (c == CH_PCT) begin
						hold_mode = MODE_NONE;
						step_bytes.push_back(CH_PCT);
					end else begin
						hold_mode = MODE_NONE;
						step_bytes.push_back(CH_PCT);
						emit_plain(c);
					end
				end
				MODE_DIGIT: begin
					hold_mode = MODE_NONE;
					if (is_hex_char(c)) begin
						step_bytes.push_back(CH_BSL);
						step_bytes.push_back(CH_X);
						step_bytes.push_back(hold_digit);
						step_bytes.push_back(c);
					end else begin
						step_bytes.push_back(CH_PCT);
						step_bytes.push_back(hold_digit);
						take_fresh(c);
					end
				end
				default: begin
					take_fresh(c);
				end
			endcase
			if (last) begin
				release_hold();
			end
		end
		foreach (step_bytes[i]) begin
			e.out_byte = step_bytes[i];
			e.out_last = last && (i == step_bytes.size() - 1);
			escaped_q.push_back(e);
		end
	endfunction

	// ------------------------------------------------------------------
	// Output checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (escaped_q.size() == 0) begin
				$display("%0t: unexpected output beat byte=%02h last=%0b", $time,
					out_data.out_byte, out_data.out_last);
				mismatch_count++;
			end else begin
				want = escaped_q.pop_front();
				if (out_data.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %02h actual %02h", $time,
						want.out_byte, out_data.out_byte);
					mismatch_count++;
				end
				if (out_data.out_last !== want.out_last) begin
					$display("%0t: out_last expected %0b actual %0b", $time,
						want.out_last, out_data.out_last);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Shared drivers
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] c, input logic last);
		int unsigned gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		in_data.in_byte <= c;
		in_data.in_last <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_escape(c, last);
		beats_sent++;
	endtask

	// Stop sending and wait until every expected byte has come out. A beat
	// that only fills the hold produces nothing, so keep waiting after the
	// queue empties to let the pipeline take it in.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (escaped_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Writes both registers back to back; the upper data bits are don't-care.
	task automatic configure(input logic esc, input logic colon);
		drain_results();
		cfg_index <= REG_ESCAPE_ENABLE;
		cfg_data <= {7'($urandom), esc};
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		esc_on = esc;
		cfg_index <= REG_ALLOW_COLON;
		cfg_data <= {7'($urandom), colon};
		do @(posedge clk); while (!cfg_ready);
		colon_ok = colon;
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Random path generation
	// ------------------------------------------------------------------
	function automatic logic [7:0] pick_raw();
		string s;
		s = "abmxyzABMXYZ0159/:";
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic logic [7:0] pick_hex();
		string s;
		s = "0123456789abcdefABCDEF";
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic logic [7:0] pick_non_hex();
		logic [7:0] c;
		do c = 8'($urandom); while (is_hex_char(c));
		return c;
	endfunction

	task automatic send_random_path();
		logic [7:0] path[$];
		int unsigned pieces;
		int unsigned cut;
		bit          closed;
		pieces = $urandom_range(1, 5);
		repeat (pieces) begin
			case ($urandom_range(0, 9))
				0, 1, 2: path.push_back(pick_raw());
				3, 4: begin
					path.push_back(CH_PCT);
					path.push_back(pick_hex());
					path.push_back(pick_hex());
				end
				5: begin
					path.push_back(CH_PCT);
					path.push_back(CH_PCT);
				end
				6: begin
					path.push_back(CH_PCT);
					path.push_back(pick_hex());
					path.push_back(pick_non_hex());
				end
				7: begin
					path.push_back(CH_PCT);
					path.push_back(pick_non_hex());
				end
				default: path.push_back(8'($urandom));
			endcase
		end
		// Cutting the tail often ends the path in the middle of a sequence.
		if ($urandom_range(0, 4) == 0 && path.size() > 1) begin
			cut = $urandom_range(1, path.size() - 1);
			while (path.size() > cut) void'(path.pop_back());
		end
		// Now and then the path runs on into the next one.
		closed = ($urandom_range(0, 7) != 0);
		foreach (path[i]) begin
			send_byte(path[i], closed && (i == path.size() - 1));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings: escaping on, colon escaped.
	task automatic test_plain_bytes();
		send_byte("a", 1'b0);
		send_byte(CH_SLASH, 1'b0);
		send_byte(CH_COLON, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
	endtask

	task automatic test_percent_sequences();
		gaps_on = 1'b1;
		stall_on = 1'b1;
		send_byte(CH_PCT, 1'b0);
		send_byte("A", 1'b0);
		send_byte("f", 1'b0);
		send_byte(CH_PCT, 1'b0);
		send_byte(CH_PCT, 1'b0);
		send_byte(CH_PCT, 1'b0);
		send_byte("-", 1'b0);
		send_byte(CH_PCT, 1'b0);
		send_byte("4", 1'b0);
		send_byte("g", 1'b0);
		// A lone percent at the end of the path is flushed raw.
		send_byte(CH_PCT, 1'b1);
		send_byte(CH_PCT, 1'b0);
		send_byte("C", 1'b1);
	endtask

	task automatic test_colon_pass();
		configure(1'b1, 1'b1);
		send_byte(CH_COLON, 1'b1);
	endtask

	// Turning escaping off while a percent or a percent and digit is held
	// must release the held bytes raw ahead of the next byte.
	task automatic test_escape_off_with_hold();
		configure(1'b1, 1'b0);
		send_byte(CH_PCT, 1'b0);
		send_byte("7", 1'b0);
		configure(1'b0, 1'b0);
		send_byte("Q", 1'b0);
		configure(1'b1, 1'b0);
		send_byte(CH_PCT, 1'b0);
		configure(1'b0, 1'b1);
		send_byte("~", 1'b1);
	endtask

	task automatic test_random_paths();
		logic [1:0] settings[6];
		int unsigned target;
		settings = '{2'b10, 2'b11, 2'b00, 2'b10, 2'b01, 2'b11};
		foreach (settings[p]) begin
			configure(settings[p][1], settings[p][0]);
			gaps_on = (p != 0) && ($urandom_range(0, 3) != 0);
			stall_on = (p != 0) && ($urandom_range(0, 3) != 0);
			target = beats_sent + 80;
			while (beats_sent < target) send_random_path();
		end
	endtask

	initial begin
		hold_mode = MODE_NONE;
		hold_digit = 8'h00;
		esc_on = 1'b1;
		colon_ok = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ESCAPE_ENABLE;
		cfg_data <= 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_plain_bytes();
		test_percent_sequences();
		test_colon_pass();
		test_escape_off_with_hold();
		test_random_paths();

		drain_results();
		if (mismatch_count == 0) begin
			$display("** path_escape_encoder: PASSED **");
		end else begin
			$display("** path_escape_encoder: FAILED **");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("%0t: timed out with %0d beats still expected", $time, escaped_q.size());
		$display("** path_escape_encoder: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
rtl/pee_pkg.sv
rtl/pee_encoder.sv
rtl/pee_serializer.sv
rtl/path_escape_encoder.sv
verif/tb.sv
